// ===== rtl/tftp_rd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tftp_rd_pkg
// Shared types and constants of the tftp read receiver.
// ---------------------------------------------------------------------------
package tftp_rd_pkg;

  // payload size of a full data block
  localparam int BLOCK_BYTES = 512;
  localparam int LEN_W       = 10;
  localparam int HDR_BYTES   = 4;

  // tftp opcodes of interest
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ERROR = 16'd5;

  // configuration reset values
  localparam logic [31:0] DEFAULT_SERVER_ADDR = 32'd0;
  localparam logic [15:0] DEFAULT_SERVER_PORT = 16'd69;
  localparam logic [7:0]  DEFAULT_RETRY_LIMIT = 8'd10;

  localparam logic [7:0]  RETRY_MAX = 8'hFF;

  typedef enum logic [1:0] {
    REG_SERVER_ADDR = 2'd0,
    REG_SERVER_PORT = 2'd1,
    REG_RETRY_LIMIT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_PACKET  = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_ABORT   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OPEN = 2'd1,
    PH_XFER = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RSP_NONE   = 2'd0,
    RSP_RRQ    = 2'd1,
    RSP_ACK    = 2'd2,
    RSP_STIFLE = 2'd3
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_XFER       = 3'd1,
    ST_COMPLETE   = 3'd2,
    ST_REMOTE_ERR = 3'd3,
    ST_RETRY_FAIL = 3'd4
  } status_t;

  // classified item passed from front to back
  typedef struct packed {
    act_t              action;
    logic              addr_match;
    logic [15:0]       sport;
    logic [15:0]       blk;
    logic              len_ok;
    logic              is_data;
    logic              is_error;
    logic [LEN_W-1:0]  data_len;
    logic              short_blk;
    logic [15:0]       ecode;
  } cls_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [15:0] server_port;
    logic [7:0]  retry_limit;
  } back_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/tftp_rd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tftp_rd_if
// Valid/ready channels for events in and results out.
// ---------------------------------------------------------------------------
interface tftp_rd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] src_addr;
  logic [15:0] src_port;
  logic [15:0] opcode;
  logic [15:0] block_num;
  logic [9:0]  packet_len;
  logic [15:0] error_code;

  modport source (output valid, action, src_addr, src_port, opcode, block_num,
                  packet_len, error_code, input ready);
  modport sink   (input valid, action, src_addr, src_port, opcode, block_num,
                  packet_len, error_code, output ready);
endinterface

interface tftp_rd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  response;
  logic [15:0] dest_port;
  logic [15:0] ack_block;
  logic        data_valid;
  logic [9:0]  data_len;
  logic        last_block;
  logic [2:0]  status;
  logic [15:0] remote_error;

  modport source (output valid, response, dest_port, ack_block, data_valid, data_len,
                  last_block, status, remote_error, input ready);
  modport sink   (input valid, response, dest_port, ack_block, data_valid, data_len,
                  last_block, status, remote_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/tftp_rd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tftp_rd_front
// Accepts events and decodes the stateless parts of each packet header.
// ---------------------------------------------------------------------------
module tftp_rd_front
  import tftp_rd_pkg::*;
(
  input  logic [31:0]         server_addr,
  tftp_rd_in_if.sink          in_ch,
  input  logic                q_full,
  output logic                push,
  output cls_t                cls
);

  localparam logic [LEN_W-1:0] BLOCK_LEN = LEN_W'(BLOCK_BYTES);
  localparam logic [LEN_W-1:0] HDR_LEN   = LEN_W'(HDR_BYTES);

  logic [LEN_W-1:0] payload_len;
  logic [LEN_W-1:0] payload_sat;

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // payload length, saturated at a full block
  assign payload_len = in_ch.packet_len - HDR_LEN;
  assign payload_sat = (payload_len > BLOCK_LEN) ? BLOCK_LEN : payload_len;

  // header classification
  always_comb begin
    cls.action     = act_t'(in_ch.action);
    cls.addr_match = (in_ch.src_addr == server_addr);
    cls.sport      = in_ch.src_port;
    cls.blk        = in_ch.block_num;
    cls.len_ok     = (in_ch.packet_len >= HDR_LEN);
    cls.is_data    = (in_ch.opcode == OP_DATA);
    cls.is_error   = (in_ch.opcode == OP_ERROR);
    cls.data_len   = payload_sat;
    cls.short_blk  = (payload_sat < BLOCK_LEN);
    cls.ecode      = in_ch.error_code;
  end

endmodule
`default_nettype wire

// ===== rtl/tftp_rd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tftp_rd_fifo
// Two-entry queue of classified items between front and back.
// ---------------------------------------------------------------------------
module tftp_rd_fifo
  import tftp_rd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  cls_t  wdata,
  output logic  full,
  input  logic  pop,
  output logic  rvalid,
  output cls_t  rdata
);

  cls_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full   = (count_r == 2'd2);
  assign rvalid = (count_r != 2'd0);
  assign rdata  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tftp_rd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tftp_rd_back
// Transfer state machine: applies one classified item per cycle while the
// output register is free or being taken, and registers its result.
// ---------------------------------------------------------------------------
module tftp_rd_back
  import tftp_rd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  back_cfg_t      cfg,
  input  logic           q_valid,
  input  cls_t           q_data,
  output logic           pop,
  tftp_rd_out_if.source  out_ch
);

  // transfer state
  phase_t      phase_r, phase_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic [15:0] peer_port_r, peer_port_nxt;
  logic [15:0] last_blk_r, last_blk_nxt;
  logic [7:0]  retry_cnt_r, retry_cnt_nxt;
  logic        end_seen_r, end_seen_nxt;
  status_t     final_st_r, final_st_nxt;
  logic [15:0] saved_err_r, saved_err_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  rsp_t             rsp_r, rsp_nxt;
  logic [15:0]      dport_r, dport_nxt;
  logic [15:0]      ack_r, ack_nxt;
  logic             dv_r, dv_nxt;
  logic [LEN_W-1:0] dlen_r, dlen_nxt;
  logic             last_r, last_nxt;
  status_t          status_r, status_nxt;
  logic [15:0]      rerr_r, rerr_nxt;

  logic        active;
  logic        ours;
  logic        do_retry;
  logic [15:0] peer_eff;
  logic [15:0] expect_blk;
  logic [7:0]  cnt_inc;

  assign pop = q_valid && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.response     = rsp_r;
  assign out_ch.dest_port    = dport_r;
  assign out_ch.ack_block    = ack_r;
  assign out_ch.data_valid   = dv_r;
  assign out_ch.data_len     = dlen_r;
  assign out_ch.last_block   = last_r;
  assign out_ch.status       = status_r;
  assign out_ch.remote_error = rerr_r;

  assign active     = (phase_r == PH_OPEN) || (phase_r == PH_XFER);
  // only a packet from the server can latch the peer port
  assign peer_eff   = (q_data.action == ACT_PACKET && q_data.addr_match && awaiting_r)
                      ? q_data.sport : peer_port_r;
  assign ours       = q_data.addr_match && (peer_eff == q_data.sport);
  assign expect_blk = last_blk_r + 16'd1;
  assign cnt_inc    = (retry_cnt_r != RETRY_MAX) ? retry_cnt_r + 8'd1 : retry_cnt_r;

  // next state and result of the item at the queue head
  always_comb begin
    phase_nxt     = phase_r;
    awaiting_nxt  = awaiting_r;
    peer_port_nxt = peer_port_r;
    last_blk_nxt  = last_blk_r;
    retry_cnt_nxt = retry_cnt_r;
    end_seen_nxt  = end_seen_r;
    final_st_nxt  = final_st_r;
    saved_err_nxt = saved_err_r;
    rsp_nxt       = RSP_NONE;
    dport_nxt     = 16'd0;
    ack_nxt       = 16'd0;
    dv_nxt        = 1'b0;
    dlen_nxt      = '0;
    last_nxt      = 1'b0;
    do_retry      = 1'b0;

    case (q_data.action)
      ACT_START: begin
        phase_nxt     = PH_OPEN;
        awaiting_nxt  = 1'b1;
        peer_port_nxt = cfg.server_port;
        last_blk_nxt  = 16'd0;
        retry_cnt_nxt = 8'd0;
        end_seen_nxt  = 1'b0;
        final_st_nxt  = ST_IDLE;
        saved_err_nxt = 16'd0;
        rsp_nxt       = RSP_RRQ;
        dport_nxt     = cfg.server_port;
      end
      ACT_PACKET: begin
        if (active) begin
          // first reply from the server latches its port
          if (q_data.addr_match && awaiting_r) begin
            awaiting_nxt  = 1'b0;
            peer_port_nxt = q_data.sport;
          end
          if (!ours) begin
            rsp_nxt   = RSP_STIFLE;
            dport_nxt = q_data.sport;
          end else if (q_data.len_ok && q_data.is_data && q_data.blk == expect_blk) begin
            last_blk_nxt  = q_data.blk;
            retry_cnt_nxt = 8'd0;
            end_seen_nxt  = q_data.short_blk;
            if (q_data.short_blk) begin
              phase_nxt    = PH_DONE;
              final_st_nxt = ST_COMPLETE;
            end else begin
              phase_nxt = PH_XFER;
            end
            rsp_nxt   = RSP_ACK;
            dport_nxt = peer_eff;
            ack_nxt   = q_data.blk;
            dv_nxt    = 1'b1;
            dlen_nxt  = q_data.data_len;
            last_nxt  = q_data.short_blk;
          end else if (q_data.len_ok && q_data.is_error) begin
            phase_nxt     = PH_DONE;
            final_st_nxt  = ST_REMOTE_ERR;
            saved_err_nxt = q_data.ecode;
          end else begin
            do_retry = 1'b1;
          end
        end
      end
      ACT_TIMEOUT: begin
        do_retry = active;
      end
      ACT_ABORT: begin
        if (phase_r != PH_IDLE) begin
          if (!end_seen_r && !awaiting_r) begin
            rsp_nxt   = RSP_STIFLE;
            dport_nxt = peer_port_r;
          end
          phase_nxt     = PH_IDLE;
          awaiting_nxt  = 1'b0;
          peer_port_nxt = 16'd0;
          last_blk_nxt  = 16'd0;
          retry_cnt_nxt = 8'd0;
          end_seen_nxt  = 1'b0;
          final_st_nxt  = ST_IDLE;
          saved_err_nxt = 16'd0;
        end
      end
      default: begin
        do_retry = 1'b0;
      end
    endcase

    // failed attempt: re-send or give up
    if (do_retry) begin
      retry_cnt_nxt = cnt_inc;
      if (cnt_inc >= cfg.retry_limit) begin
        phase_nxt    = PH_DONE;
        final_st_nxt = ST_RETRY_FAIL;
      end else begin
        dport_nxt = peer_eff;
        if (phase_r == PH_OPEN) begin
          rsp_nxt = RSP_RRQ;
        end else begin
          rsp_nxt = RSP_ACK;
          ack_nxt = last_blk_r;
        end
      end
    end

    // status follows the new phase
    case (phase_nxt)
      PH_IDLE: status_nxt = ST_IDLE;
      PH_DONE: status_nxt = final_st_nxt;
      default: status_nxt = ST_XFER;
    endcase
    rerr_nxt = saved_err_nxt;

    out_valid_nxt = pop ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  // state registers, advanced only when an item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      awaiting_r  <= 1'b0;
      peer_port_r <= 16'd0;
      last_blk_r  <= 16'd0;
      retry_cnt_r <= 8'd0;
      end_seen_r  <= 1'b0;
      final_st_r  <= ST_IDLE;
      saved_err_r <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r     <= phase_nxt;
        awaiting_r  <= awaiting_nxt;
        peer_port_r <= peer_port_nxt;
        last_blk_r  <= last_blk_nxt;
        retry_cnt_r <= retry_cnt_nxt;
        end_seen_r  <= end_seen_nxt;
        final_st_r  <= final_st_nxt;
        saved_err_r <= saved_err_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      rsp_r    <= rsp_nxt;
      dport_r  <= dport_nxt;
      ack_r    <= ack_nxt;
      dv_r     <= dv_nxt;
      dlen_r   <= dlen_nxt;
      last_r   <= last_nxt;
      status_r <= status_nxt;
      rerr_r   <= rerr_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tftp_read_receiver_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tftp_read_receiver_top
// Receive side of a tftp read client, one event item in, one result out.
// ---------------------------------------------------------------------------
// in_ch carries events: start, parsed packet header, reply timeout, abort.
// out_ch returns one result item per event: the packet to emit (read
// request, ack or stifle error), accepted payload info and transfer status.
// cfg_we/cfg_index/cfg_wdata write server address, server port and retry
// limit; write them only while no item is in flight.
// From input accept, an item is registered in the two-entry classify queue,
// then passes through the state machine into the output register.
// Throughput is one item per cycle while out_ch does not stall, set by
// the back end, which updates its state once per item taken.
// When out_ch stalls, the output register holds its item, the queue fills
// and in_ch.ready drops once both queue entries are taken.
// Synchronous reset returns the transfer to idle, empties the queue and
// restores configuration defaults (port 69, retry limit 10).
// ---------------------------------------------------------------------------
module tftp_read_receiver_top
  import tftp_rd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  tftp_rd_in_if.sink    in_ch,
  tftp_rd_out_if.source out_ch,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

  logic [31:0] server_addr_r;
  logic [15:0] server_port_r;
  logic [7:0]  retry_limit_r;
  back_cfg_t   back_cfg;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cls_t q_wdata;
  cls_t q_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_addr_r <= DEFAULT_SERVER_ADDR;
      server_port_r <= DEFAULT_SERVER_PORT;
      retry_limit_r <= DEFAULT_RETRY_LIMIT;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SERVER_ADDR: server_addr_r <= cfg_wdata;
        REG_SERVER_PORT: server_port_r <= cfg_wdata[15:0];
        REG_RETRY_LIMIT: retry_limit_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign back_cfg.server_port = server_port_r;
  assign back_cfg.retry_limit = retry_limit_r;

  // classify front end
  tftp_rd_front u_front (
    .server_addr (server_addr_r),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .push        (q_push),
    .cls         (q_wdata)
  );

  // queue between front and back
  tftp_rd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // transfer state machine and output register
  tftp_rd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (back_cfg),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ===== rtl/tftp_rd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tftp_rd_checker
// Port-level checks on the result channel of the read receiver.
// ---------------------------------------------------------------------------
module tftp_rd_checker
  import tftp_rd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  response,
  input logic [15:0] dest_port,
  input logic [15:0] ack_block,
  input logic        data_valid,
  input logic [9:0]  data_len,
  input logic        last_block
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(response) && $stable(dest_port)
      && $stable(ack_block) && $stable(data_valid))
    else $error("stalled result changed");

  // no packet means no port and no ack number
  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && response == RSP_NONE |-> dest_port == 16'd0 && ack_block == 16'd0)
    else $error("empty response carries port or block");

  // accepted payload always comes with an ack, otherwise no length flags
  a_data_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (data_valid && response == RSP_ACK)
      || (!data_valid && data_len == 10'd0 && !last_block))
    else $error("payload info inconsistent with response");

endmodule

bind tftp_read_receiver_top tftp_rd_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .response   (out_ch.response),
  .dest_port  (out_ch.dest_port),
  .ack_block  (out_ch.ack_block),
  .data_valid (out_ch.data_valid),
  .data_len   (out_ch.data_len),
  .last_block (out_ch.last_block)
);
`default_nettype wire
